@@ hw/rtl/ran_pkg.sv @@
// Package for the rational arithmetic normalize block: widths, operation and
// status codes. No dependencies.
`timescale 1ns / 1ps
package ran_pkg;
  localparam int WIDTH_DEF = 32;
  localparam int FIELD_W = 32;
  localparam int OP_W = 3;
  localparam int ST_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_NEG = 3'd4, OP_INC = 3'd5, OP_DEC = 3'd6, OP_NORM = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_OVERFLOW = 2'd2
  } status_t;
endpackage

@@ hw/rtl/ran_if.sv @@
// Valid/ready channel interfaces for the input and result words.
// Depends on ran_pkg.
`timescale 1ns / 1ps
interface ran_in_if import ran_pkg::*; ();
  logic valid;
  logic ready;
  logic [OP_W-1:0] operation;
  logic signed [FIELD_W-1:0] left_num;
  logic signed [FIELD_W-1:0] left_den;
  logic signed [FIELD_W-1:0] right_num;
  logic signed [FIELD_W-1:0] right_den;
  modport source (output valid, operation, left_num, left_den, right_num, right_den,
                  input ready);
  modport sink (input valid, operation, left_num, left_den, right_num, right_den,
                output ready);
endinterface

interface ran_out_if import ran_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [FIELD_W-1:0] result_num;
  logic signed [FIELD_W-1:0] result_den;
  logic [ST_W-1:0] status;
  modport source (output valid, result_num, result_den, status, input ready);
  modport sink (input valid, result_num, result_den, status, output ready);
endinterface

@@ hw/rtl/ran_divu.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, used for both the
// Euclid remainders and the final reduction. Depends on ran_pkg.
`timescale 1ns / 1ps
module ran_divu import ran_pkg::*; #(
  parameter int DW = 2 * WIDTH_DEF + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [DW-1:0] remainder
);
  localparam int CW = $clog2(DW + 1);
  logic [DW-1:0] q_r, q_nxt, rem_r, rem_nxt, dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0] trial;

  always_comb begin
    trial = {rem_r, q_r[DW-1]} - {1'b0, dvs_r};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      // shift in next dividend bit; keep trial result if it did not borrow
      if (!trial[DW]) begin
        rem_nxt = trial[DW-1:0];
        q_nxt = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-2:0], q_r[DW-1]};
        q_nxt = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r <= CW'(DW);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quotient = q_r;
  assign remainder = rem_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r)) else $error("divider done while busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider count ran out while busy");
`endif
endmodule

@@ hw/rtl/rational_arith_normalize_core.sv @@
// Top level of the rational arithmetic normalize block: sequencer around one
// multiplier and one shared divider. Depends on ran_pkg, ran_if, ran_divu.
`timescale 1ns / 1ps
// Usage:
//   in  (ran_in_if.sink): operation and two fractions, one word per item.
//   out (ran_out_if.source): reduced numerator, denominator and status.
//   The block takes one word, then drops in_ready until its result has been
//   taken. Work: up to three WIDTH x WIDTH products on one multiplier, a
//   sign/magnitude add, then Euclid's loop where each remainder costs one
//   pass of the shared divider, then two more divider passes for n/g and d/g.
//   The number of Euclid steps sets the total time, and long Fibonacci-like
//   pairs take the most steps. Zero numerator and zero denominator skip the
//   divider.
//   The result sits in an output register; while the receiver stalls it
//   holds, and the next word is accepted once it has been taken.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   out_valid; no clearing pass is needed since the data registers are loaded afresh for each word.
module rational_arith_normalize_core import ran_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  ran_in_if.sink    in,
  ran_out_if.source out
);
  localparam int MW = 2 * WIDTH;     // product magnitude
  localparam int DW = MW + 1;        // sum magnitude

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_SUM, S_CHECK, S_GCD_GO, S_GCD_WT,
    S_DN_GO, S_DN_WT, S_DD_GO, S_DD_WT, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic [OP_W-1:0] op_r;
  logic [WIDTH-1:0] lnm_r, ldm_r, rnm_r, rdm_r;
  logic lns_r, lds_r, rns_r, rds_r;
  logic [MW-1:0] p0_r, p1_r, pd_r;   // ln*x, rn*ld, denominator product
  logic [DW-1:0] nm_r, dm_r, ga_r, gb_r, qn_r;
  logic nneg_r, dneg_r;
  logic signed [FIELD_W-1:0] onum_r, oden_r;
  logic [ST_W-1:0] ost_r;
  logic ovalid_r;

  // shared multiplier operands
  logic [WIDTH-1:0] ma, mb;
  logic [MW-1:0] mp;
  assign mp = MW'(ma) * MW'(mb);

  // take low WIDTH bits and split into sign/magnitude
  function automatic logic [WIDTH:0] take(input logic [FIELD_W-1:0] raw);
    logic [WIDTH-1:0] x;
    x = raw[WIDTH-1:0];
    return {x[WIDTH-1], x[WIDTH-1] ? (~x + 1'b1) : x};
  endfunction

  logic [WIDTH:0] tln, tld, trn, trd;
  assign tln = take(in.left_num);
  assign tld = take(in.left_den);
  assign trn = take(in.right_num);
  assign trd = take(in.right_den);

  // sign of each product term
  logic s0, s1;
  assign s0 = lns_r ^ ((op_r == OP_MUL) ? rns_r : rds_r);
  assign s1 = rns_r ^ lds_r ^ (op_r == OP_SUB);

  // shared divider
  logic dv_start, dv_done;
  logic [DW-1:0] dv_a, dv_b, dv_q, dv_rem;
  ran_divu #(.DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
    .divisor(dv_b), .done(dv_done), .quotient(dv_q), .remainder(dv_rem)
  );

  always_comb begin
    ma = lnm_r;
    mb = rdm_r;
    case (state_r)
      S_M0: begin ma = lnm_r; mb = (op_r == OP_MUL) ? rnm_r : rdm_r; end
      S_M1: begin ma = rnm_r; mb = ldm_r; end
      S_M2: begin ma = ldm_r; mb = (op_r == OP_DIV) ? rnm_r : rdm_r; end
      default: begin ma = lnm_r; mb = rdm_r; end
    endcase
    dv_start = (state_r == S_GCD_GO) || (state_r == S_DN_GO) || (state_r == S_DD_GO);
    case (state_r)
      S_DN_GO: begin dv_a = nm_r; dv_b = ga_r; end
      S_DD_GO: begin dv_a = dm_r; dv_b = ga_r; end
      default: begin dv_a = ga_r; dv_b = gb_r; end
    endcase
  end

  // signed sum of two sign/magnitude terms
  function automatic logic [DW:0] sadd(input logic as, input logic [DW-1:0] am,
                                       input logic bs, input logic [DW-1:0] bm);
    logic [DW-1:0] m;
    logic s;
    if (as == bs) begin m = am + bm; s = as; end
    else if (am >= bm) begin m = am - bm; s = as; end
    else begin m = bm - am; s = bs; end
    return {s && (m != '0), m};
  endfunction

  logic [DW:0] sum;
  logic [DW-1:0] lim;
  logic neg_res;
  assign lim = DW'(1) << (WIDTH - 1);
  assign neg_res = nneg_r ^ dneg_r;

  always_comb begin
    sum = '0;
    case (op_r)
      OP_ADD, OP_SUB: sum = sadd(s0, DW'(p0_r), s1, DW'(p1_r));
      OP_INC: sum = sadd(lns_r, DW'(lnm_r), lds_r, DW'(ldm_r));
      OP_DEC: sum = sadd(lns_r, DW'(lnm_r), !lds_r, DW'(ldm_r));
      OP_NEG: sum = {!lns_r && (lnm_r != '0), DW'(lnm_r)};
      OP_MUL, OP_DIV: sum = {s0 && (p0_r != '0), DW'(p0_r)};
      default: sum = {lns_r, DW'(lnm_r)};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in.valid) begin
          op_r <= in.operation;
          {lns_r, lnm_r} <= tln;
          {lds_r, ldm_r} <= tld;
          {rns_r, rnm_r} <= trn;
          {rds_r, rdm_r} <= trd;
          state_r <= S_M0;
        end
        S_M0: begin p0_r <= mp; state_r <= S_M1; end
        S_M1: begin p1_r <= mp; state_r <= S_M2; end
        S_M2: begin pd_r <= mp; state_r <= S_SUM; end
        S_SUM: begin
          {nneg_r, nm_r} <= sum;
          if (op_r == OP_ADD || op_r == OP_SUB || op_r == OP_MUL || op_r == OP_DIV) begin
            dm_r <= DW'(pd_r);
            dneg_r <= (pd_r != '0) && (lds_r ^ ((op_r == OP_DIV) ? rns_r : rds_r));
          end else begin
            dm_r <= DW'(ldm_r);
            dneg_r <= lds_r;
          end
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          ga_r <= nm_r;
          gb_r <= dm_r;
          if (dm_r == '0) begin
            onum_r <= '0; oden_r <= '0; ost_r <= ST_ZERO_DEN;
            state_r <= S_OUT;
          end else if (nm_r == '0) begin
            // zero keeps the denominator's sign as plus or minus one
            onum_r <= '0;
            oden_r <= dneg_r ? -FIELD_W'(1) : FIELD_W'(1);
            ost_r <= ST_OK;
            state_r <= S_OUT;
          end else begin
            state_r <= S_GCD_GO;
          end
        end
        S_GCD_GO: state_r <= S_GCD_WT;
        S_GCD_WT: if (dv_done) begin
          ga_r <= gb_r;
          gb_r <= dv_rem;
          state_r <= (dv_rem == '0) ? S_DN_GO : S_GCD_GO;
        end
        S_DN_GO: state_r <= S_DN_WT;
        S_DN_WT: if (dv_done) begin qn_r <= dv_q; state_r <= S_DD_GO; end
        S_DD_GO: state_r <= S_DD_WT;
        S_DD_WT: if (dv_done) begin gb_r <= dv_q; state_r <= S_FIN; end
        S_FIN: begin
          if (gb_r > lim - 1'b1 || qn_r > (neg_res ? lim : lim - 1'b1)) begin
            onum_r <= '0; oden_r <= '0; ost_r <= ST_OVERFLOW;
          end else begin
            onum_r <= FIELD_W'($signed(neg_res ? (~qn_r[WIDTH-1:0] + 1'b1)
                                               : qn_r[WIDTH-1:0]));
            oden_r <= FIELD_W'(gb_r[WIDTH-1:0]);
            ost_r <= ST_OK;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid_r) begin
            ovalid_r <= 1'b1;
          end else if (out.ready) begin
            ovalid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in.ready = (state_r == S_IDLE);
  assign out.valid = ovalid_r;
  assign out.result_num = onum_r;
  assign out.result_den = oden_r;
  assign out.status = ost_r;

`ifndef SYNTHESIS
  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> state_r == S_OUT) else $error("result valid outside output state");
  a_not_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in.ready) else $error("input ready while result pending");
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (in.valid && in.ready) |=> state_r == S_M0) else $error("accept did not start");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (ost_r != ST_OK || oden_r != '0)) else $error("ok with zero denominator");
`endif
endmodule

@@ sim/tb_rational_arith_normalize_core.sv @@
// Testbench for rational_arith_normalize_core: directed table, then random
// fraction words, checked against typed answers or an in-bench rational reducer.
// Depends on ran_pkg, ran_if and the core RTL.
`timescale 1ns / 1ps
module tb_rational_arith_normalize_core;
  import ran_pkg::*;

  localparam int W = WIDTH_DEF;
  localparam int N_RANDOM = 480;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    bit neg;
    longint unsigned mag;
  } frac_part_t;

  typedef struct {
    logic signed [FIELD_W-1:0] num;
    logic signed [FIELD_W-1:0] den;
    status_t st;
  } reduced_t;

  typedef struct {
    op_t op;
    logic signed [FIELD_W-1:0] ln, ld, rn, rd;
    bit typed;
    reduced_t res;
  } word_t;

  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  logic clk;
  logic rst_n;
  ran_in_if  in_ch ();
  ran_out_if out_ch ();

  rational_arith_normalize_core #(.WIDTH(W)) DUT (
    .clk(clk), .rst_n(rst_n), .in(in_ch), .out(out_ch)
  );

  reduced_t expected_q[$];
  int n_errors = 0;
  int n_results = 0;
  int n_sent = 0;
  bit no_idle = 0;
  longint cycles = 0;

  // Free-running clock, 10 ns period.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rational_arith_normalize_core test failed");
      $finish;
    end
  end

  function automatic frac_part_t to_part(logic [FIELD_W-1:0] x);
    frac_part_t p;
    logic [W-1:0] v;
    v = x[W-1:0];
    p.neg = v[W-1];
    p.mag = p.neg ? ((64'd1 << W) - 64'(v)) : 64'(v);
    return p;
  endfunction

  function automatic frac_part_t part_mul(frac_part_t a, frac_part_t b);
    frac_part_t r;
    r.mag = a.mag * b.mag;
    r.neg = (r.mag != 0) && (a.neg != b.neg);
    return r;
  endfunction

  function automatic frac_part_t part_neg(frac_part_t a);
    a.neg = (a.mag != 0) && !a.neg;
    return a;
  endfunction

  function automatic frac_part_t part_add(frac_part_t a, frac_part_t b);
    frac_part_t r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function automatic logic [31:0] signed_word(bit neg, longint unsigned mag);
    longint unsigned v;
    v = neg ? (64'd0 - mag) : mag;
    return v[31:0];
  endfunction

  // Form the exact raw fraction, then reduce it by Euclid's gcd.
  function automatic reduced_t reduce_fraction(word_t w);
    reduced_t r;
    frac_part_t ln, ld, rn, rd, n, d;
    longint unsigned a, b, t, lim;
    bit neg;
    ln = to_part(w.ln);
    ld = to_part(w.ld);
    rn = to_part(w.rn);
    rd = to_part(w.rd);
    case (w.op)
      OP_ADD: begin
        n = part_add(part_mul(ln, rd), part_mul(rn, ld));
        d = part_mul(ld, rd);
      end
      OP_SUB: begin
        n = part_add(part_mul(ln, rd), part_neg(part_mul(rn, ld)));
        d = part_mul(ld, rd);
      end
      OP_MUL: begin n = part_mul(ln, rn); d = part_mul(ld, rd); end
      OP_DIV: begin n = part_mul(ln, rd); d = part_mul(ld, rn); end
      OP_NEG: begin n = part_neg(ln); d = ld; end
      OP_INC: begin n = part_add(ln, ld); d = ld; end
      OP_DEC: begin n = part_add(ln, part_neg(ld)); d = ld; end
      default: begin n = ln; d = ld; end
    endcase
    r.num = 0;
    r.den = 0;
    r.st = ST_OK;
    if (d.mag == 0) begin
      r.st = ST_ZERO_DEN;
      return r;
    end
    if (n.mag == 0) begin
      r.den = signed_word(d.neg, 1);
      return r;
    end
    neg = n.neg != d.neg;
    a = n.mag;
    b = d.mag;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    n.mag = n.mag / a;
    d.mag = d.mag / a;
    lim = 64'd1 << (W - 1);
    if (d.mag > lim - 1 || n.mag > (neg ? lim : lim - 1)) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.num = signed_word(neg, n.mag);
    r.den = signed_word(0, d.mag);
    return r;
  endfunction

  // Mix of tiny, mid-size, full-range and boundary operands.
  function automatic logic signed [31:0] pick_operand();
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) return $signed($urandom_range(40)) - 20;
    if (sel < 60) return $signed($urandom_range(200000)) - 100000;
    if (sel < 75) return $urandom;
    case ($urandom_range(4))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return MAXV;
      default: return MINV;
    endcase
  endfunction

  function automatic word_t row(op_t op, logic signed [31:0] ln, ld, rn, rd, bit typed,
                                logic signed [31:0] en, ed, status_t st);
    word_t w;
    w.op = op; w.ln = ln; w.ld = ld; w.rn = rn; w.rd = rd;
    w.typed = typed;
    w.res.num = en; w.res.den = ed; w.res.st = st;
    return w;
  endfunction

  // Drive one word: optional idle gap, then hold valid until accepted.
  task automatic send_word(word_t w);
    int gap;
    gap = 0;
    if (!no_idle)
      while ($urandom_range(99) < 33) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= w.op;
    in_ch.left_num <= w.ln;
    in_ch.left_den <= w.ld;
    in_ch.right_num <= w.rn;
    in_ch.right_den <= w.rd;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(w.typed ? w.res : reduce_fraction(w));
    n_sent++;
  endtask

  // Receiver: stall at random except during the no-idle stretch.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    reduced_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d status %0d", $time,
                 out_ch.result_num, out_ch.result_den, out_ch.status);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.result_num !== e.num) begin
          $display("%0t: result_num expected %0d actual %0d", $time, e.num,
                   out_ch.result_num);
          n_errors++;
        end
        if (out_ch.result_den !== e.den) begin
          $display("%0t: result_den expected %0d actual %0d", $time, e.den,
                   out_ch.result_den);
          n_errors++;
        end
        if (out_ch.status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_ch.status);
          n_errors++;
        end
      end
    end
  end

  initial begin
    word_t table_rows[$];
    word_t w;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ADD;
    in_ch.left_num = 0;
    in_ch.left_den = 0;
    in_ch.right_num = 0;
    in_ch.right_den = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: typed where the answer is obvious, predictor otherwise.
    table_rows.push_back(row(OP_NORM, 0, 5, 0, 0, 1, 0, 1, ST_OK));
    table_rows.push_back(row(OP_NORM, 0, -5, 0, 0, 1, 0, -1, ST_OK));
    table_rows.push_back(row(OP_NORM, 3, 0, 0, 0, 1, 0, 0, ST_ZERO_DEN));
    table_rows.push_back(row(OP_DIV, 1, 1, 0, 7, 1, 0, 0, ST_ZERO_DEN));
    table_rows.push_back(row(OP_NORM, 6, 4, 0, 0, 1, 3, 2, ST_OK));
    table_rows.push_back(row(OP_NORM, MINV, 1, 0, 0, 1, MINV, 1, ST_OK));
    table_rows.push_back(row(OP_NORM, 1, MINV, 0, 0, 1, 0, 0, ST_OVERFLOW));
    table_rows.push_back(row(OP_NEG, MINV, 1, 0, 0, 1, 0, 0, ST_OVERFLOW));
    table_rows.push_back(row(OP_MUL, MAXV, 1, MAXV, 1, 1, 0, 0, ST_OVERFLOW));
    table_rows.push_back(row(OP_NORM, MAXV, MAXV, 0, 0, 1, 1, 1, ST_OK));
    table_rows.push_back(row(OP_SUB, 1, 3, 1, 3, 1, 0, 1, ST_OK));
    table_rows.push_back(row(OP_ADD, 1, 2, 1, 3, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_ADD, MINV, MINV, MINV, MINV, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_SUB, 5, -7, 2, 9, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_MUL, -4, 9, 3, -8, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_DIV, 2, 3, -4, 9, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_INC, -7, 3, 0, 0, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_INC, MAXV, 1, 0, 0, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_DEC, MINV, 1, 0, 0, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_DEC, 7, -3, 123, 0, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_NEG, 9, -12, MAXV, MINV, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_NORM, 1134903170, 1836311903, 0, 0, 0, 0, 0, ST_OK));
    table_rows.push_back(row(OP_ADD, MAXV, MAXV, MINV, MAXV, 0, 0, 0, ST_OK));
    foreach (table_rows[i]) send_word(table_rows[i]);

    // Random words; hold off once until drained, and run a no-idle stretch.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 150) begin
        in_ch.valid <= 1'b0;
        wait (expected_q.size() == 0);
        @(posedge clk);
      end
      no_idle = (i >= 300 && i < 360);
      w.op = op_t'($urandom_range(7));
      w.ln = pick_operand();
      w.ld = pick_operand();
      w.rn = pick_operand();
      w.rd = pick_operand();
      w.typed = 0;
      send_word(w);
    end
    in_ch.valid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (400) @(posedge clk);
    $display("Covered %0d words across all eight operations, %0d results checked,",
             n_sent, n_results);
    $display("including zero, overflow and full-range operands under random stalls.");
    if (n_errors == 0 && expected_q.size() == 0)
      $display("rational_arith_normalize_core test passed");
    else
      $display("rational_arith_normalize_core test failed");
    $finish;
  end
endmodule
